>>> rtl/sism_pkg.sv
// Package for the sorted interval set merge unit: types, op and status codes.
package sism_pkg;

  localparam int unsigned DefaultDepth = 16;
  localparam int unsigned LimitWidth   = 5;
  localparam int unsigned InDataWidth  = 200;
  localparam int unsigned OutDataWidth = 136;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpMember = 2'd1,
    OpRead   = 2'd2,
    OpClear  = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusEmpty   = 2'd1,
    StatusLimit   = 2'd2,
    StatusUnused  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    StIdle,
    StScanFirst,
    StScanAfter,
    StShiftUp,
    StShiftDown,
    StWrite,
    StScanMember,
    StReply
  } state_e;

  // classified word handed from front to back
  typedef struct packed {
    op_e         op;
    logic        empty;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] query;
    logic [3:0]  index;
  } cmd_t;

  typedef struct packed {
    logic [1:0]  status;
    logic        found;
    logic [63:0] out_start;
    logic [63:0] out_stop;
    logic [4:0]  range_count;
  } result_t;

endpackage

>>> rtl/sism_front.sv
// Front end: takes input words, classifies them and queues commands.
module sism_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  output logic                s_tready_o,
  input  logic [199:0]        s_tdata_i,
  output logic                cmd_valid_o,
  input  logic                cmd_ready_i,
  output sism_pkg::cmd_t      cmd_o
);
  import sism_pkg::*;

  // two-entry queue
  cmd_t       mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;
  cmd_t       in_cmd;
  logic       push, pop;

  always_comb begin
    in_cmd.op    = op_e'(s_tdata_i[1:0]);
    in_cmd.lo    = s_tdata_i[65:2];
    in_cmd.hi    = s_tdata_i[129:66];
    in_cmd.query = s_tdata_i[193:130];
    in_cmd.index = s_tdata_i[197:194];
    in_cmd.empty = (s_tdata_i[65:2] >= s_tdata_i[129:66]);
  end

  assign s_tready_o  = (cnt_q != 2'd2);
  assign push        = s_tvalid_i && s_tready_o;
  assign cmd_valid_o = (cnt_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_ready_i;
  assign cmd_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wr_ptr_q] <= in_cmd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/sism_back.sv
// Back end: sequencer that scans, shifts and writes the range store.
module sism_back #(
  parameter int unsigned DEPTH = sism_pkg::DefaultDepth,
  localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int unsigned CW = $clog2(DEPTH + 1)
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [4:0]           cfg_wdata_i,
  input  logic                 cmd_valid_i,
  output logic                 cmd_ready_o,
  input  sism_pkg::cmd_t       cmd_i,
  output logic                 res_valid_o,
  input  logic                 res_ready_i,
  output sism_pkg::result_t    res_o
);
  import sism_pkg::*;

  logic [63:0] starts_q [DEPTH];
  logic [63:0] stops_q  [DEPTH];

  state_e                state_q, state_d;
  cmd_t                  cmd_q, cmd_d;
  logic [CW-1:0]         count_q, count_d;
  logic [CW-1:0]         first_q, first_d, after_q, after_d;
  logic [CW-1:0]         ptr_q, ptr_d, dst_q, dst_d;
  logic [63:0]           lo_q, lo_d, hi_q, hi_d;
  logic [LimitWidth-1:0] limit_q;
  logic [1:0]            status_q, status_d;
  logic                  hit_q, hit_d;
  result_t               res_q, res_d;
  logic                  res_valid_q, res_valid_d;

  // single registered read port; address follows ptr_d so read data lines up with ptr_q
  logic [IW-1:0] rd_addr;
  logic [63:0]   rd_start_q, rd_stop_q;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [63:0]   wr_start, wr_stop;
  logic [CW-1:0] eff_limit;
  logic          accept;
  logic          first_go, after_go, member_hit, index_ok;

  assign eff_limit   = (32'(limit_q) > DEPTH) ? CW'(DEPTH) : CW'(limit_q);
  assign cmd_ready_o = (state_q == StIdle) && !res_valid_q;
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign first_go   = (ptr_q < count_q) && (rd_stop_q < lo_q);
  assign after_go   = (ptr_q < count_q) && (rd_start_q <= hi_q);
  assign member_hit = (ptr_q < count_q) && (cmd_q.query >= rd_start_q)
                      && (cmd_q.query < rd_stop_q);
  assign index_ok   = 32'(cmd_q.index) < 32'(count_q);

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      starts_q[wr_addr] <= wr_start;
      stops_q[wr_addr]  <= wr_stop;
    end
    rd_start_q <= starts_q[rd_addr];
    rd_stop_q  <= stops_q[rd_addr];
  end

  always_comb begin
    rd_addr = ptr_d[IW-1:0];
    // shifting up copies ptr-1 into ptr
    if (state_d == StShiftUp) rd_addr = IW'(ptr_d - CW'(1));
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StIdle:
        if (accept) begin
          case (cmd_i.op)
            OpInsert: state_d = cmd_i.empty ? StReply : StScanFirst;
            OpMember: state_d = StScanMember;
            default:  state_d = StReply;
          endcase
        end
      StScanFirst:
        if (!first_go) state_d = StScanAfter;
      StScanAfter:
        if (!after_go) begin
          if (ptr_q == first_q) begin
            state_d = (count_q >= eff_limit) ? StReply : StShiftUp;
          end else if (ptr_q - first_q > CW'(1)) state_d = StShiftDown;
          else state_d = StWrite;
        end
      StShiftUp:
        if (ptr_q <= first_q) state_d = StWrite;
      StShiftDown:
        if (ptr_q >= count_q) state_d = StWrite;
      StWrite:      state_d = StReply;
      StScanMember:
        if (ptr_q >= count_q || member_hit) state_d = StReply;
      StReply:      state_d = StIdle;
      default:      state_d = StIdle;
    endcase
  end

  always_comb begin
    cmd_d    = cmd_q;
    count_d  = count_q;
    first_d  = first_q;
    after_d  = after_q;
    ptr_d    = ptr_q;
    dst_d    = dst_q;
    lo_d     = lo_q;
    hi_d     = hi_q;
    hit_d    = hit_q;
    status_d = status_q;
    wr_en    = 1'b0;
    wr_addr  = ptr_q[IW-1:0];
    wr_start = rd_start_q;
    wr_stop  = rd_stop_q;
    case (state_q)
      StIdle:
        if (accept) begin
          cmd_d    = cmd_i;
          lo_d     = cmd_i.lo;
          hi_d     = cmd_i.hi;
          hit_d    = 1'b0;
          status_d = (cmd_i.op == OpInsert && cmd_i.empty) ? StatusEmpty : StatusOk;
          ptr_d    = (cmd_i.op == OpRead) ? CW'(cmd_i.index) : '0;
          if (cmd_i.op == OpClear) count_d = '0;
        end
      StScanFirst:
        if (first_go) ptr_d = ptr_q + CW'(1);
        else first_d = ptr_q;
      StScanAfter:
        if (after_go) begin
          if (rd_start_q < lo_q) lo_d = rd_start_q;
          if (rd_stop_q > hi_q)  hi_d = rd_stop_q;
          ptr_d = ptr_q + CW'(1);
        end else begin
          after_d = ptr_q;
          dst_d   = first_q + CW'(1);
          if (ptr_q == first_q) begin
            if (count_q >= eff_limit) status_d = StatusLimit;
            else ptr_d = count_q;
          end
        end
      StShiftUp:
        // walk down from count, opening a slot at first
        if (ptr_q > first_q) begin
          wr_en   = 1'b1;
          wr_addr = ptr_q[IW-1:0];
          ptr_d   = ptr_q - CW'(1);
        end else begin
          count_d = count_q + CW'(1);
        end
      StShiftDown:
        // close the gap left by the merged entries
        if (ptr_q < count_q) begin
          wr_en   = 1'b1;
          wr_addr = dst_q[IW-1:0];
          ptr_d   = ptr_q + CW'(1);
          dst_d   = dst_q + CW'(1);
        end else begin
          count_d = count_q - (after_q - first_q - CW'(1));
        end
      StWrite: begin
        wr_en    = 1'b1;
        wr_addr  = first_q[IW-1:0];
        wr_start = lo_q;
        wr_stop  = hi_q;
      end
      StScanMember:
        if (member_hit) hit_d = 1'b1;
        else if (ptr_q < count_q) ptr_d = ptr_q + CW'(1);
      default: ;
    endcase
  end

  always_comb begin
    res_d       = res_q;
    res_valid_d = res_valid_q;
    if (res_valid_q && res_ready_i) res_valid_d = 1'b0;
    if (state_q == StReply) begin
      res_valid_d       = 1'b1;
      res_d.status      = status_q;
      res_d.out_start   = '0;
      res_d.out_stop    = '0;
      res_d.range_count = 5'(count_q);
      case (cmd_q.op)
        OpMember: res_d.found = hit_q;
        OpRead: begin
          res_d.found = index_ok;
          if (index_ok) begin
            res_d.out_start = rd_start_q;
            res_d.out_stop  = rd_stop_q;
          end
        end
        default:  res_d.found = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cmd_q       <= '0;
      count_q     <= '0;
      first_q     <= '0;
      after_q     <= '0;
      ptr_q       <= '0;
      dst_q       <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      hit_q       <= 1'b0;
      status_q    <= StatusOk;
      limit_q     <= LimitWidth'(16);
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cmd_q       <= cmd_d;
      count_q     <= count_d;
      first_q     <= first_d;
      after_q     <= after_d;
      ptr_q       <= ptr_d;
      dst_q       <= dst_d;
      lo_q        <= lo_d;
      hi_q        <= hi_d;
      hit_q       <= hit_d;
      status_q    <= status_d;
      res_q       <= res_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) limit_q <= cfg_wdata_i;
    end
  end
endmodule

>>> rtl/sorted_interval_set_merge_unit.sv
// Membership makes one scan pass; insert makes one scan pass plus at most one shift pass.
// Throughput: one word in the sequencer at a time, stepping one store entry per cycle
// through a registered read port; the next word is accepted once the result is taken.
// A two-word command queue keeps taking input meanwhile.
// Reset (rst_ni low, asynchronous) empties the set and sets range_limit to 16; the store is not cleared.
module sorted_interval_set_merge_unit #(
  parameter int unsigned DEPTH = sism_pkg::DefaultDepth
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         cfg_we_i,
  input  logic [4:0]   cfg_wdata_i,
  input  logic         s_tvalid_i,
  output logic         s_tready_o,
  // op, range_start, range_stop, query_value, entry_index, zero pad
  input  logic [199:0] s_tdata_i,
  output logic         m_tvalid_o,
  input  logic         m_tready_i,
  // status, found, out_start, out_stop, range_count
  output logic [135:0] m_tdata_o
);
  import sism_pkg::*;

  logic    cmd_valid, cmd_ready;
  cmd_t    cmd;
  result_t res;

  sism_front u_front (
    .clk_i, .rst_ni, .s_tvalid_i, .s_tready_o, .s_tdata_i,
    .cmd_valid_o(cmd_valid), .cmd_ready_i(cmd_ready), .cmd_o(cmd)
  );

  sism_back #(.DEPTH(DEPTH)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i,
    .cmd_valid_i(cmd_valid), .cmd_ready_o(cmd_ready), .cmd_i(cmd),
    .res_valid_o(m_tvalid_o), .res_ready_i(m_tready_i), .res_o(res)
  );

  assign m_tdata_o = {res.range_count, res.out_stop, res.out_start,
                      res.found, res.status};

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> m_tdata_o[1:0] != StatusUnused)
    else $error("bad status");
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> 32'(m_tdata_o[135:131]) <= DEPTH)
    else $error("count over depth");
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o && !m_tready_i |=> m_tvalid_o && $stable(m_tdata_o))
    else $error("result dropped");
endmodule
